[rtl/ddc_pkg.sv]
package ddc_pkg;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int DUTY_W  = 16;
    localparam int VOLT_W  = 16;
    localparam int LIM_W   = 15;
    localparam int MUL_W   = 17;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DVD_W   = 31;

    localparam logic [LIM_W-1:0]  RST_MAX_DUTY      = 15'd32767;
    localparam logic [VOLT_W-1:0] RST_MAX_STEP      = 16'd65535;
    localparam logic [VOLT_W-1:0] RST_FILTER_GAIN   = 16'd6554;
    localparam logic [VOLT_W-1:0] RST_MIN_VOLTAGE   = 16'd1;
    localparam logic [VOLT_W-1:0] RST_FULL_VOLTAGE  = 16'd24000;
    localparam logic [LIM_W-1:0]  RST_MAX_COMP_DUTY = 15'd32767;

    typedef enum logic [2:0] {
        REG_MAX_DUTY      = 3'd0,
        REG_MAX_STEP      = 3'd1,
        REG_FILTER_GAIN   = 3'd2,
        REG_MIN_VOLTAGE   = 3'd3,
        REG_FULL_VOLTAGE  = 3'd4,
        REG_MAX_COMP_DUTY = 3'd5,
        REG_COMP_ENABLE   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [LIM_W-1:0]  max_duty;
        logic [VOLT_W-1:0] max_step;
        logic [VOLT_W-1:0] filter_gain;
        logic [VOLT_W-1:0] min_voltage;
        logic [VOLT_W-1:0] full_voltage;
        logic [LIM_W-1:0]  max_comp_duty;
        logic              comp_enable;
    } cfg_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              ovf;
        logic [VOLT_W-1:0] quo;
    } div_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_FILT,
        S_LEVEL,
        S_MUL_L,
        S_DIV_L,
        S_WAIT_L,
        S_MUL_R,
        S_DIV_R,
        S_WAIT_R,
        S_DONE
    } state_t;

endpackage

[rtl/drive_duty_conditioner.sv]
// steps per word: capture, slew limit, filter multiply and battery level; with
// compensation on, a multiply and a divide for the left side, then the right side,
// on the one-bit-per-cycle divider shared by both sides (an overflow ends early)
// new words are accepted only in the idle state, after the last one is output
// reset: synchronous active-low aresetn restores register defaults and zeroes the
// previous duties and the filtered battery level
module drive_duty_conditioner (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ddc_pkg::ADDR_W-1:0]           paddr,
    input  logic [ddc_pkg::DATA_W-1:0]           pwdata,
    output logic [ddc_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ddc_pkg::DUTY_W-1:0]    s_left_request,
    input  logic signed [ddc_pkg::DUTY_W-1:0]    s_right_request,
    input  logic                                 s_reverse,
    input  logic [ddc_pkg::VOLT_W-1:0]           s_vin_front_left,
    input  logic [ddc_pkg::VOLT_W-1:0]           s_vin_front_right,
    input  logic [ddc_pkg::VOLT_W-1:0]           s_vin_back_right,
    input  logic [ddc_pkg::VOLT_W-1:0]           s_vin_back_left,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ddc_pkg::DUTY_W-1:0]    m_left_duty,
    output logic signed [ddc_pkg::DUTY_W-1:0]    m_right_duty,
    output logic [ddc_pkg::VOLT_W-1:0]           m_battery_level,
    output logic                                 m_low_battery
);
    import ddc_pkg::*;

    // symmetric clamp of a 17-bit signed request to +/-lim
    function automatic logic signed [DUTY_W-1:0] clamp_sym(
        input logic signed [DUTY_W:0] v,
        input logic [LIM_W-1:0]       lim
    );
        logic signed [DUTY_W:0] pl;
        logic signed [DUTY_W:0] nl;
        pl = signed'({2'b00, lim});
        nl = -pl;
        if (v > pl) begin
            return pl[DUTY_W-1:0];
        end else if (v < nl) begin
            return nl[DUTY_W-1:0];
        end
        return v[DUTY_W-1:0];
    endfunction

    // move from last toward target by at most step
    function automatic logic signed [DUTY_W-1:0] slew(
        input logic signed [DUTY_W-1:0] target,
        input logic signed [DUTY_W-1:0] last,
        input logic [VOLT_W-1:0]        step
    );
        logic signed [DUTY_W+1:0] t;
        logic signed [DUTY_W+1:0] l;
        logic signed [DUTY_W+1:0] s;
        logic signed [DUTY_W+1:0] d;
        logic signed [DUTY_W+1:0] r;
        t = signed'({{2{target[DUTY_W-1]}}, target});
        l = signed'({{2{last[DUTY_W-1]}}, last});
        s = signed'({2'b00, step});
        d = t - l;
        r = t;
        if (d > s) begin
            r = l + s;
        end else if (d < -s) begin
            r = l - s;
        end
        return r[DUTY_W-1:0];
    endfunction

    // saturate the quotient magnitude and restore the sign
    function automatic logic signed [DUTY_W-1:0] comp_side(
        input div_res_t         dr,
        input logic             neg,
        input logic [LIM_W-1:0] lim
    );
        logic [VOLT_W-1:0] mag;
        mag = dr.quo;
        if (dr.ovf || (dr.quo > {1'b0, lim})) begin
            mag = {1'b0, lim};
        end
        return neg ? signed'(-mag) : signed'(mag);
    endfunction

    cfg_t cfg;

    ddc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg, state_next;

    // captured input word
    logic signed [DUTY_W-1:0] lreq_reg, rreq_reg;
    logic                     rev_reg;
    logic [VOLT_W-1:0]        avg_reg;

    // slew limiter and filter state
    logic signed [DUTY_W-1:0] prev_l_reg, prev_r_reg;
    logic [VOLT_W-1:0]        fv_reg;

    // per-word working values
    logic [VOLT_W-1:0]        level_reg;
    logic                     low_reg;
    logic                     neg_reg;
    logic signed [DUTY_W-1:0] comp_l_reg, comp_r_reg;

    // result word held for the consumer
    logic                     m_valid_reg;
    logic signed [DUTY_W-1:0] out_l_reg, out_r_reg;
    logic [VOLT_W-1:0]        out_lvl_reg;
    logic                     out_low_reg;

    logic                     accept;
    logic                     load_out;
    logic [VOLT_W+1:0]        vin_sum;
    logic signed [DUTY_W:0]   lsel, rsel;
    logic signed [DUTY_W-1:0] l_slew, r_slew;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0]        prod_mag;
    logic signed [DUTY_W+1:0] lvl_sum;
    logic [VOLT_W-1:0]        lvl_raw;
    logic [VOLT_W-1:0]        floor_v;
    logic                     div_start;
    div_res_t                 div_res;

    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign vin_sum  = {2'b00, s_vin_front_left} + {2'b00, s_vin_front_right}
                    + {2'b00, s_vin_back_right} + {2'b00, s_vin_back_left};

    // reverse swaps and negates; minus full scale negates to +32768 here
    assign lsel = rev_reg ? -signed'({rreq_reg[DUTY_W-1], rreq_reg})
                          :  signed'({lreq_reg[DUTY_W-1], lreq_reg});
    assign rsel = rev_reg ? -signed'({lreq_reg[DUTY_W-1], lreq_reg})
                          :  signed'({rreq_reg[DUTY_W-1], rreq_reg});

    assign l_slew = slew(clamp_sym(lsel, cfg.max_duty), prev_l_reg, cfg.max_step);
    assign r_slew = slew(clamp_sym(rsel, cfg.max_duty), prev_r_reg, cfg.max_step);

    // filter step: level + floor(k * (avg - level) / 2^16)
    assign lvl_sum = signed'({2'b00, fv_reg}) + signed'(mul_p[PROD_W-1:VOLT_W]);
    assign lvl_raw = lvl_sum[VOLT_W-1:0];
    assign floor_v = (cfg.min_voltage == '0) ? VOLT_W'(1) : cfg.min_voltage;

    assign prod_mag = mul_p[PROD_W-1] ? unsigned'(-mul_p) : unsigned'(mul_p);

    ddc_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    ddc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_mag[DVD_W-1:0]),
        .divisor  (level_reg),
        .res      (div_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_PREP;
            S_PREP:   state_next = S_FILT;
            S_FILT:   state_next = S_LEVEL;
            S_LEVEL:  state_next = cfg.comp_enable ? S_MUL_L : S_DONE;
            S_MUL_L:  state_next = S_DIV_L;
            S_DIV_L:  state_next = S_WAIT_L;
            S_WAIT_L: if (div_res.done) state_next = S_MUL_R;
            S_MUL_R:  state_next = S_DIV_R;
            S_DIV_R:  state_next = S_WAIT_R;
            S_WAIT_R: if (div_res.done) state_next = S_DONE;
            S_DONE:   if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: input ready, shared multiplier operands and divider start
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_FILT: begin
                mul_a = signed'({1'b0, avg_reg}) - signed'({1'b0, fv_reg});
                mul_b = signed'({1'b0, cfg.filter_gain});
            end
            S_MUL_L: begin
                mul_a = signed'({prev_l_reg[DUTY_W-1], prev_l_reg});
                mul_b = signed'({1'b0, cfg.full_voltage});
            end
            S_MUL_R: begin
                mul_a = signed'({prev_r_reg[DUTY_W-1], prev_r_reg});
                mul_b = signed'({1'b0, cfg.full_voltage});
            end
            S_DIV_L, S_DIV_R: div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            fv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // the slew-limited duty, not the compensated one, is remembered
            if (state_reg == S_PREP) begin
                prev_l_reg <= l_slew;
                prev_r_reg <= r_slew;
            end
            if (state_reg == S_LEVEL) begin
                fv_reg <= (lvl_raw < floor_v) ? floor_v : lvl_raw;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            lreq_reg <= s_left_request;
            rreq_reg <= s_right_request;
            rev_reg  <= s_reverse;
            avg_reg  <= vin_sum[VOLT_W+1:2];
        end
        if (state_reg == S_LEVEL) begin
            level_reg <= (lvl_raw < floor_v) ? floor_v : lvl_raw;
            low_reg   <= lvl_raw < floor_v;
        end
        if (state_reg == S_DIV_L || state_reg == S_DIV_R) begin
            neg_reg <= mul_p[PROD_W-1];
        end
        if (state_reg == S_WAIT_L && div_res.done) begin
            comp_l_reg <= comp_side(div_res, neg_reg, cfg.max_comp_duty);
        end
        if (state_reg == S_WAIT_R && div_res.done) begin
            comp_r_reg <= comp_side(div_res, neg_reg, cfg.max_comp_duty);
        end
        if (load_out) begin
            out_l_reg   <= cfg.comp_enable ? comp_l_reg : prev_l_reg;
            out_r_reg   <= cfg.comp_enable ? comp_r_reg : prev_r_reg;
            out_lvl_reg <= level_reg;
            out_low_reg <= low_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_duty     = out_l_reg;
    assign m_right_duty    = out_r_reg;
    assign m_battery_level = out_lvl_reg;
    assign m_low_battery   = out_low_reg;

    // divider is never restarted while it still iterates
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_res.busy)
        else $error("divider started while busy");

    // the floor keeps the divisor nonzero
    a_level_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL_L || state_reg == S_MUL_R) |-> (level_reg != '0))
        else $error("zero battery level reached the divider");

    // a finished word always lands in the output register
    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result word not loaded");

    // remembered duty never reaches minus full scale
    a_prev_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (prev_l_reg != 16'sh8000) && (prev_r_reg != 16'sh8000))
        else $error("previous duty out of range");

endmodule

[rtl/ddc_regs.sv]
module ddc_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ddc_pkg::ADDR_W-1:0]    paddr,
    input  logic [ddc_pkg::DATA_W-1:0]    pwdata,
    output logic [ddc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output ddc_pkg::cfg_t                 cfg
);
    import ddc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_duty      <= RST_MAX_DUTY;
            cfg_reg.max_step      <= RST_MAX_STEP;
            cfg_reg.filter_gain   <= RST_FILTER_GAIN;
            cfg_reg.min_voltage   <= RST_MIN_VOLTAGE;
            cfg_reg.full_voltage  <= RST_FULL_VOLTAGE;
            cfg_reg.max_comp_duty <= RST_MAX_COMP_DUTY;
            cfg_reg.comp_enable   <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_MAX_DUTY:      cfg_reg.max_duty      <= pwdata[LIM_W-1:0];
                REG_MAX_STEP:      cfg_reg.max_step      <= pwdata[VOLT_W-1:0];
                REG_FILTER_GAIN:   cfg_reg.filter_gain   <= pwdata[VOLT_W-1:0];
                REG_MIN_VOLTAGE:   cfg_reg.min_voltage   <= pwdata[VOLT_W-1:0];
                REG_FULL_VOLTAGE:  cfg_reg.full_voltage  <= pwdata[VOLT_W-1:0];
                REG_MAX_COMP_DUTY: cfg_reg.max_comp_duty <= pwdata[LIM_W-1:0];
                REG_COMP_ENABLE:   cfg_reg.comp_enable   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_MAX_DUTY:      prdata = DATA_W'(cfg_reg.max_duty);
            REG_MAX_STEP:      prdata = DATA_W'(cfg_reg.max_step);
            REG_FILTER_GAIN:   prdata = DATA_W'(cfg_reg.filter_gain);
            REG_MIN_VOLTAGE:   prdata = DATA_W'(cfg_reg.min_voltage);
            REG_FULL_VOLTAGE:  prdata = DATA_W'(cfg_reg.full_voltage);
            REG_MAX_COMP_DUTY: prdata = DATA_W'(cfg_reg.max_comp_duty);
            REG_COMP_ENABLE:   prdata = DATA_W'(cfg_reg.comp_enable);
            default:           prdata = '0;
        endcase
    end

endmodule

[rtl/ddc_mul.sv]
module ddc_mul (
    input  logic                                aclk,
    input  logic signed [ddc_pkg::MUL_W-1:0]    a,
    input  logic signed [ddc_pkg::MUL_W-1:0]    b,
    output logic signed [ddc_pkg::PROD_W-1:0]   p
);
    import ddc_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    // registered signed product, shared by the filter and both sides
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

[rtl/ddc_div.sv]
module ddc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ddc_pkg::DVD_W-1:0]     dividend,
    input  logic [ddc_pkg::VOLT_W-1:0]    divisor,
    output ddc_pkg::div_res_t             res
);
    import ddc_pkg::*;

    localparam int CNT_W = $clog2(VOLT_W);

    logic              busy_reg;
    logic              done_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [VOLT_W-1:0] rem_reg;
    logic [VOLT_W-1:0] dvd_reg;
    logic [VOLT_W-1:0] dsr_reg;
    logic [VOLT_W:0]   trial;
    logic              too_big;

    // quotient of 2^16 or more only matters as saturation
    assign too_big = {1'b0, dividend[DVD_W-1:VOLT_W]} >= divisor;
    assign trial   = {rem_reg, dvd_reg[VOLT_W-1]} - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                ovf_reg <= too_big;
                if (too_big) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(VOLT_W - 1);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, dividend[DVD_W-1:VOLT_W]};
            dvd_reg <= dividend[VOLT_W-1:0];
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[VOLT_W]) begin
                rem_reg <= trial[VOLT_W-1:0];
            end else begin
                rem_reg <= {rem_reg[VOLT_W-2:0], dvd_reg[VOLT_W-1]};
            end
            dvd_reg <= {dvd_reg[VOLT_W-2:0], ~trial[VOLT_W]};
        end
    end

    assign res.busy = busy_reg;
    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = dvd_reg;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ddc_pkg::*;

    // register slot past the last defined one, writes there must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // cycles the result side holds off in the back-pressure phase
    localparam int LONG_HOLD = 300;
    // words in each random phase, one settings draw per phase
    localparam int PHASE_WORDS = 125;
    localparam int NUM_PHASES = 8;
    // printed mismatch lines stop here, counting goes on
    localparam int MAX_REPORTS = 100;

    // one input word as offered on the s_ side
    typedef struct packed {
        logic [DUTY_W-1:0] left_request;
        logic [DUTY_W-1:0] right_request;
        logic              reverse;
        logic [VOLT_W-1:0] vin_fl;
        logic [VOLT_W-1:0] vin_fr;
        logic [VOLT_W-1:0] vin_br;
        logic [VOLT_W-1:0] vin_bl;
    } duty_req_t;

    // one conditioned word as seen on the m_ side
    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [VOLT_W-1:0] battery_level;
        logic              low_battery;
    } duty_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // configuration port, always driven to known values
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // request side
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DUTY_W-1:0] s_left_request = '0;
    logic signed [DUTY_W-1:0] s_right_request = '0;
    logic                     s_reverse = 1'b0;
    logic [VOLT_W-1:0]        s_vin_front_left = '0;
    logic [VOLT_W-1:0]        s_vin_front_right = '0;
    logic [VOLT_W-1:0]        s_vin_back_right = '0;
    logic [VOLT_W-1:0]        s_vin_back_left = '0;

    // result side
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DUTY_W-1:0] m_left_duty;
    logic signed [DUTY_W-1:0] m_right_duty;
    logic [VOLT_W-1:0]        m_battery_level;
    logic                     m_low_battery;

    // words waiting to be offered, and predicted words waiting to come out
    duty_req_t duty_requests[$];
    duty_res_t conditioned_duties[$];
    duty_req_t offered_request;

    // predictor copy of the settings and of the block state
    cfg_t              cfg_model;
    int                kept_left;
    int                kept_right;
    logic [VOLT_W-1:0] battery_level_q;

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    // long hold request: toggled by the stimulus, seen by the result side
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    // periodic window in which neither side idles
    wire no_idle = (cycle_count % 5000) >= 3500;

    drive_duty_conditioner uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_left_request    (s_left_request),
        .s_right_request   (s_right_request),
        .s_reverse         (s_reverse),
        .s_vin_front_left  (s_vin_front_left),
        .s_vin_front_right (s_vin_front_right),
        .s_vin_back_right  (s_vin_back_right),
        .s_vin_back_left   (s_vin_back_left),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_left_duty       (m_left_duty),
        .m_right_duty      (m_right_duty),
        .m_battery_level   (m_battery_level),
        .m_low_battery     (m_low_battery)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic int clamp_sym(int v, int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // move from last toward target by at most step
    function automatic int slew_step(int target, int last, int step);
        if (target - last > step) return last + step;
        if (target - last < -step) return last - step;
        return target;
    endfunction

    // duty * full / level, truncated toward zero, then the compensated clamp
    function automatic int compensate(int duty, int lvl);
        longint q;
        q = (longint'(duty) * longint'(cfg_model.full_voltage)) / longint'(lvl);
        // |duty| <= 32767 keeps q inside 32 bits
        return clamp_sym(int'(q), int'(cfg_model.max_comp_duty));
    endfunction

    // next output word for an accepted request, advancing the kept state
    function automatic duty_res_t condition_duty(input duty_req_t w);
        int        lreq;
        int        rreq;
        int        lsel;
        int        rsel;
        int        l;
        int        r;
        int        avg;
        int        floor_v;
        int        lvl;
        longint    prod;
        duty_res_t res;
        lreq = $signed(w.left_request);
        rreq = $signed(w.right_request);
        // reverse swaps the sides and flips their sign
        lsel = w.reverse ? -rreq : lreq;
        rsel = w.reverse ? -lreq : rreq;
        l = slew_step(clamp_sym(lsel, int'(cfg_model.max_duty)), kept_left,
                      int'(cfg_model.max_step));
        r = slew_step(clamp_sym(rsel, int'(cfg_model.max_duty)), kept_right,
                      int'(cfg_model.max_step));
        kept_left = l;
        kept_right = r;
        // truncated average, then one filter step with floor rounding
        avg = (int'(w.vin_fl) + int'(w.vin_fr) + int'(w.vin_br) + int'(w.vin_bl)) >> 2;
        prod = longint'(cfg_model.filter_gain) * longint'(avg - int'(battery_level_q));
        lvl = int'((longint'(battery_level_q) + (prod >>> 16)) & 64'hFFFF);
        // a zero floor acts as one so the divisor never vanishes
        floor_v = (cfg_model.min_voltage == '0) ? 1 : int'(cfg_model.min_voltage);
        res.low_battery = (lvl < floor_v);
        if (lvl < floor_v) lvl = floor_v;
        battery_level_q = lvl[VOLT_W-1:0];
        if (cfg_model.comp_enable) begin
            l = compensate(l, lvl);
            r = compensate(r, lvl);
        end
        res.left_duty = l[DUTY_W-1:0];
        res.right_duty = r[DUTY_W-1:0];
        res.battery_level = lvl[VOLT_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // request driver
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // prediction happens on the edge that accepts the word
            if (s_valid && s_ready) begin
                conditioned_duties.push_back(condition_duty(offered_request));
            end
            if (s_valid && !s_ready) begin
                // word still pending, payload stays put
            end else if (duty_requests.size() != 0 &&
                         (no_idle || $urandom_range(99) >= 30)) begin
                offered_request = duty_requests.pop_front();
                s_valid <= 1'b1;
                s_left_request <= offered_request.left_request;
                s_right_request <= offered_request.right_request;
                s_reverse <= offered_request.reverse;
                s_vin_front_left <= offered_request.vin_fl;
                s_vin_front_right <= offered_request.vin_fr;
                s_vin_back_right <= offered_request.vin_br;
                s_vin_back_left <= offered_request.vin_bl;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor and ready driver
    // ---------------------------------------------------------------

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("%0t mismatch on %0s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        duty_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (conditioned_duties.size() == 0) begin
                    flag_mismatch("unexpected word", 1, 0);
                end else begin
                    want = conditioned_duties.pop_front();
                    if (m_left_duty !== want.left_duty)
                        flag_mismatch("left_duty", m_left_duty, $signed(want.left_duty));
                    if (m_right_duty !== want.right_duty)
                        flag_mismatch("right_duty", m_right_duty, $signed(want.right_duty));
                    if (m_battery_level !== want.battery_level)
                        flag_mismatch("battery_level", m_battery_level, want.battery_level);
                    if (m_low_battery !== want.low_battery)
                        flag_mismatch("low_battery", m_low_battery, want.low_battery);
                end
            end
            // long hold-off counted here, random stalls otherwise
            if (hold_toggle != hold_seen) begin
                hold_seen <= hold_toggle;
                hold_left <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= 30);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // apb write: setup cycle, access cycle, register lands on the access edge
    task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_DUTY:      cfg_model.max_duty = val[LIM_W-1:0];
            REG_MAX_STEP:      cfg_model.max_step = val[VOLT_W-1:0];
            REG_FILTER_GAIN:   cfg_model.filter_gain = val[VOLT_W-1:0];
            REG_MIN_VOLTAGE:   cfg_model.min_voltage = val[VOLT_W-1:0];
            REG_FULL_VOLTAGE:  cfg_model.full_voltage = val[VOLT_W-1:0];
            REG_MAX_COMP_DUTY: cfg_model.max_comp_duty = val[LIM_W-1:0];
            REG_COMP_ENABLE:   cfg_model.comp_enable = val[0];
            default: ;
        endcase
    endtask

    task automatic push_request(input int l, input int r, input bit rev,
                                input int fl, input int fr, input int br, input int bl);
        duty_req_t w;
        w.left_request = l[DUTY_W-1:0];
        w.right_request = r[DUTY_W-1:0];
        w.reverse = rev;
        w.vin_fl = fl[VOLT_W-1:0];
        w.vin_fr = fr[VOLT_W-1:0];
        w.vin_br = br[VOLT_W-1:0];
        w.vin_bl = bl[VOLT_W-1:0];
        duty_requests.push_back(w);
    endtask

    // sampled on the falling edge so the driver and monitor have settled
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (duty_requests.size() != 0 || s_valid || conditioned_duties.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    function automatic int pick(int lo, int hi, int mid);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return mid;
        endcase
    endfunction

    function automatic int random_duty();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(200) - 100;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // mostly near a nominal pack, sometimes anywhere, sometimes at the rails
    function automatic int random_volts();
        case ($urandom_range(19))
            0: return 0;
            1: return 65535;
            2, 3: return $urandom_range(65535);
            default: return $urandom_range(26000, 18000);
        endcase
    endfunction

    initial begin
        cfg_model = '{max_duty: RST_MAX_DUTY, max_step: RST_MAX_STEP,
                      filter_gain: RST_FILTER_GAIN, min_voltage: RST_MIN_VOLTAGE,
                      full_voltage: RST_FULL_VOLTAGE, max_comp_duty: RST_MAX_COMP_DUTY,
                      comp_enable: 1'b0};
        kept_left = 0;
        kept_right = 0;
        battery_level_q = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: full-scale requests, reverse, negated minus full scale
        push_request(-32768, 32767, 0, 0, 0, 0, 0);
        push_request(-32768, 32767, 1, 65535, 65535, 65535, 65535);
        push_request(32767, -32768, 1, 65535, 0, 65535, 0);
        push_request(0, 0, 0, 24000, 24000, 24000, 24000);
        push_request(-1, 1, 1, 1, 2, 3, 4);
        wait_drained();

        // zero step limit holds the previous duty
        cfg_write(REG_MAX_DUTY, 16384);
        cfg_write(REG_MAX_STEP, 0);
        @(negedge aclk);
        push_request(20000, -20000, 0, 24000, 24000, 24000, 24000);
        push_request(0, 0, 1, 24000, 24000, 24000, 24000);
        wait_drained();

        // smallest nonzero step
        cfg_write(REG_MAX_STEP, 1);
        @(negedge aclk);
        push_request(32767, -32768, 0, 23000, 23000, 23000, 23000);
        push_request(32767, -32768, 0, 23000, 23000, 23000, 23000);
        wait_drained();

        // zero duty clamp
        cfg_write(REG_MAX_STEP, 65535);
        cfg_write(REG_MAX_DUTY, 0);
        @(negedge aclk);
        push_request(12345, -12345, 0, 24000, 24000, 24000, 24000);
        wait_drained();

        // compensation with a zero nominal voltage
        cfg_write(REG_MAX_DUTY, 32767);
        cfg_write(REG_COMP_ENABLE, 1);
        cfg_write(REG_FULL_VOLTAGE, 0);
        @(negedge aclk);
        push_request(30000, -30000, 0, 24000, 24000, 24000, 24000);
        wait_drained();

        // zero floor with a full-weight filter: level drops to one, duty saturates
        cfg_write(REG_FULL_VOLTAGE, 65535);
        cfg_write(REG_MIN_VOLTAGE, 0);
        cfg_write(REG_FILTER_GAIN, 65535);
        @(negedge aclk);
        push_request(-32768, 32767, 0, 0, 0, 0, 0);
        push_request(-32768, 32767, 1, 65535, 65535, 65535, 65535);
        wait_drained();

        // zero compensated clamp, and a write past the last register
        cfg_write(REG_MAX_COMP_DUTY, 0);
        cfg_write(REG_UNUSED, 32'h0000_1234);
        @(negedge aclk);
        push_request(30000, 30000, 0, 20000, 20000, 20000, 20000);
        wait_drained();

        // frozen filter below a high floor: low flag on the first word, then the level sits at the floor
        cfg_write(REG_MAX_COMP_DUTY, 32767);
        cfg_write(REG_FULL_VOLTAGE, 24000);
        cfg_write(REG_MIN_VOLTAGE, 65535);
        cfg_write(REG_FILTER_GAIN, 0);
        @(negedge aclk);
        push_request(16000, -8000, 0, 24000, 24000, 24000, 24000);
        push_request(-16000, 8000, 1, 100, 200, 300, 400);
        wait_drained();

        // random phases, fresh settings each time, compensation on odd phases
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            cfg_write(REG_MAX_DUTY, pick(0, 32767, $urandom_range(32767, 8000)));
            cfg_write(REG_MAX_STEP, pick(0, 65535, $urandom_range(4000, 1)));
            cfg_write(REG_FILTER_GAIN, pick(0, 65535, $urandom_range(65535)));
            cfg_write(REG_MIN_VOLTAGE, pick(0, 65535, $urandom_range(22000, 1)));
            cfg_write(REG_FULL_VOLTAGE, pick(1, 65535, $urandom_range(26000, 20000)));
            cfg_write(REG_MAX_COMP_DUTY, pick(0, 32767, $urandom_range(32767)));
            cfg_write(REG_COMP_ENABLE, ph % 2);
            @(negedge aclk);
            // one phase runs into a long result hold-off with words still queued
            if (ph == 2) hold_toggle <= ~hold_toggle;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                push_request(random_duty(), random_duty(), $urandom_range(1),
                             random_volts(), random_volts(), random_volts(), random_volts());
            end
            wait_drained();
        end

        // room for anything still in flight after the last word
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
